[design/assert_macros.svh]
// assertion macros shared by the tiled grid address design
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/tgw_pkg.sv]
// types and constants of the tiled grid address block
// no dependencies
`timescale 1ns / 1ps

package tgw_pkg;

    localparam int GRID_W = 21;
    localparam int TILE_W = 17;
    localparam int MODE_W = 2;
    localparam int HDR_W  = 16;
    localparam int OFF_W  = 48;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TILES_ACROSS = 3'd4;
    localparam logic [IDX_W-1:0] REG_WRAP_MODE    = 3'd5;
    localparam logic [IDX_W-1:0] REG_HEADER_BYTES = 3'd6;

    localparam logic [MODE_W-1:0] WRAP_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] WRAP_WIDTH = 2'd1;
    localparam logic [MODE_W-1:0] WRAP_WM1   = 2'd2;

    localparam logic [HDR_W-1:0] HEADER_RESET = 16'd5000;

    typedef struct packed {
        logic [GRID_W-1:0] grid_width;
        logic [GRID_W-1:0] grid_height;
        logic [TILE_W-1:0] tile_width;
        logic [TILE_W-1:0] tile_height;
        logic [TILE_W-1:0] tiles_across;
        logic [MODE_W-1:0] wrap_mode;
        logic [HDR_W-1:0]  header_bytes;
    } cfg_t;

    typedef struct packed {
        logic              col_in;
        logic              neg;
        logic [GRID_W-1:0] col_lo;
        logic [GRID_W-1:0] row;
        logic              miss;
    } mod_side_t;

endpackage

[design/tgw_if.sv]
// item and configuration channel interfaces
// depends on tgw_pkg
`timescale 1ns / 1ps

interface tgw_in_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] col_index;
    logic signed [COORD_BITS-1:0] row_index;
    modport source (output valid, col_index, row_index, input ready);
    modport sink (input valid, col_index, row_index, output ready);
endinterface

interface tgw_out_if;
    logic                      valid;
    logic                      ready;
    logic [tgw_pkg::OFF_W-1:0] byte_offset;
    logic                      missing;
    modport source (output valid, byte_offset, missing, input ready);
    modport sink (input valid, byte_offset, missing, output ready);
endinterface

interface tgw_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tgw_pkg::IDX_W-1:0]  index;
    logic [tgw_pkg::DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/tgw_cfg.sv]
// configuration register file
// depends on tgw_pkg and tgw_cfg_if
`timescale 1ns / 1ps

module tgw_cfg (
    input  logic          clk,
    input  logic          rst_n,
    tgw_cfg_if.sink       cfg_ch,
    output tgw_pkg::cfg_t cfg
);
    import tgw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_GRID_WIDTH:   cfg_next.grid_width   = cfg_ch.data[GRID_W-1:0];
                REG_GRID_HEIGHT:  cfg_next.grid_height  = cfg_ch.data[GRID_W-1:0];
                REG_TILE_WIDTH:   cfg_next.tile_width   = cfg_ch.data[TILE_W-1:0];
                REG_TILE_HEIGHT:  cfg_next.tile_height  = cfg_ch.data[TILE_W-1:0];
                REG_TILES_ACROSS: cfg_next.tiles_across = cfg_ch.data[TILE_W-1:0];
                REG_WRAP_MODE:    cfg_next.wrap_mode    = cfg_ch.data[MODE_W-1:0];
                REG_HEADER_BYTES: cfg_next.header_bytes = cfg_ch.data[HDR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width   <= GRID_W'(2);
            cfg_reg.grid_height  <= GRID_W'(1);
            cfg_reg.tile_width   <= TILE_W'(1);
            cfg_reg.tile_height  <= TILE_W'(1);
            cfg_reg.tiles_across <= TILE_W'(1);
            cfg_reg.wrap_mode    <= WRAP_NONE;
            cfg_reg.header_bytes <= HEADER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/tgw_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// no package dependency
`timescale 1ns / 1ps

module tgw_div #(
    parameter int NW = 21,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_out
);

    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic [NW-1:0] vld_reg;

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] p_num;
        logic [NW-1:0] p_quo;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic          p_vld;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign p_num  = num;
            assign p_quo  = '0;
            assign p_rem  = '0;
            assign p_den  = den;
            assign p_side = side_in;
            assign p_vld  = in_vld;
        end
        else
        begin : g_rest
            assign p_num  = num_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
            assign p_vld  = vld_reg[k-1];
        end

        assign trial    = {p_rem, p_num[NW-1]};
        assign ge       = trial >= {1'b0, p_den};
        assign rem_next = ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= {p_num[NW-2:0], 1'b0};
                quo_reg[k]  <= {p_quo[NW-2:0], ge};
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign quo      = quo_reg[NW-1];
    assign rem      = rem_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

[design/tgw_offset.sv]
// tile number, in-tile offset and final byte offset, four register stages
// depends on tgw_pkg
`timescale 1ns / 1ps

module tgw_offset #(
    parameter int SAMPLE_BYTES = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tgw_pkg::cfg_t             cfg,
    input  logic                      in_vld,
    input  logic                      in_miss,
    input  logic [tgw_pkg::GRID_W-1:0] qx,
    input  logic [tgw_pkg::TILE_W-1:0] rx,
    input  logic [tgw_pkg::GRID_W-1:0] qy,
    input  logic [tgw_pkg::TILE_W-1:0] ry,
    output logic                      out_vld,
    output logic                      out_miss,
    output logic [tgw_pkg::OFF_W-1:0] out_off
);
    import tgw_pkg::*;

    localparam int TN_W   = GRID_W + TILE_W + 1;
    localparam int GN_W   = 2 * TILE_W + 1;
    localparam int AREA_W = 2 * TILE_W;
    localparam int LO_W   = 24;
    localparam int HI_W   = TN_W - LO_W;
    localparam int SB_W   = 4;

    logic [2:0]        vld_reg;
    logic [2:0]        miss_reg;
    logic [TN_W-1:0]   tn_reg;
    logic [GN_W-1:0]   gn1_reg;
    logic [AREA_W-1:0] area_reg;
    logic [OFF_W-1:0]  pp_lo_reg;
    logic [LO_W-1:0]   pp_hi_reg;
    logic [GN_W-1:0]   gn2_reg;
    logic [OFF_W-1:0]  sum_reg;
    logic              out_vld_reg;
    logic              out_miss_reg;
    logic [OFF_W-1:0]  off_reg;

    logic [AREA_W+LO_W-1:0] pp_lo_full;
    logic [AREA_W+HI_W-1:0] pp_hi_full;
    logic [OFF_W-1:0]       off_next;

    assign pp_lo_full = AREA_W'(area_reg) * tn_reg[LO_W-1:0];
    assign pp_hi_full = AREA_W'(area_reg) * tn_reg[TN_W-1:LO_W];
    assign off_next   = OFF_W'(cfg.header_bytes)
                      + OFF_W'(sum_reg * SB_W'(SAMPLE_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[1:0], in_vld};
            out_vld_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss_reg     <= {miss_reg[1:0], in_miss};
            tn_reg       <= TN_W'(qx) + TN_W'(qy * cfg.tiles_across);
            gn1_reg      <= GN_W'(rx) + GN_W'(ry * cfg.tile_width);
            area_reg     <= cfg.tile_width * cfg.tile_height;
            pp_lo_reg    <= pp_lo_full[OFF_W-1:0];
            pp_hi_reg    <= pp_hi_full[LO_W-1:0];
            gn2_reg      <= gn1_reg;
            sum_reg      <= pp_lo_reg + {pp_hi_reg, {LO_W{1'b0}}} + OFF_W'(gn2_reg);
            out_miss_reg <= miss_reg[2];
            off_reg      <= miss_reg[2] ? '0 : off_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_miss = out_miss_reg;
    assign out_off  = off_reg;

endmodule

[design/tiled_grid_address_with_wrap.sv]
// pipeline: range check, COORD_BITS-stage column modulo divider, wrap fix, 21-stage
// tile divider, four offset stages; throughput one item per cycle, the whole pipe holds on stall
// reset: asynchronous active low, clears valid bits and loads register defaults
// depends on tgw_pkg, tgw_if, tgw_cfg, tgw_div, tgw_offset and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tiled_grid_address_with_wrap #(
    parameter int SAMPLE_BYTES = 4,
    parameter int COORD_BITS   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tgw_in_if.sink    in_ch,
    tgw_out_if.source out_ch,
    tgw_cfg_if.sink   cfg_ch
);
    import tgw_pkg::*;

    localparam int EW = ((COORD_BITS > GRID_W) ? COORD_BITS : GRID_W) + 2;
    localparam int SIDE_W = $bits(mod_side_t);

    cfg_t cfg;
    logic adv;

    logic                  s1_vld_reg;
    logic [COORD_BITS-1:0] s1_abs_reg;
    mod_side_t             s1_side_reg;
    logic                  s2_vld_reg;
    logic [GRID_W-1:0]     s2_ix_reg;
    logic [GRID_W-1:0]     s2_row_reg;
    logic                  s2_miss_reg;

    logic signed [EW-1:0]  col_ext;
    logic signed [EW-1:0]  row_ext;
    logic signed [EW-1:0]  w_ext;
    logic signed [EW-1:0]  h_ext;
    logic                  col_in;
    logic                  row_in;
    logic                  wrap_ok;
    logic [GRID_W-1:0]     period;
    mod_side_t             s1_side_next;
    logic [COORD_BITS-1:0] abs_next;

    logic                  m_vld;
    logic [GRID_W-1:0]     m_rem;
    mod_side_t             m_side;
    logic [GRID_W-1:0]     ix_next;

    logic                  x_vld;
    logic [GRID_W-1:0]     qx;
    logic [TILE_W-1:0]     rx;
    logic [0:0]            x_miss;
    logic                  y_vld;
    logic [GRID_W-1:0]     qy;
    logic [TILE_W-1:0]     ry;
    logic [0:0]            y_miss;

    tgw_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // range check and wrap period
    assign col_ext = EW'(in_ch.col_index);
    assign row_ext = EW'(in_ch.row_index);
    assign w_ext   = $signed(EW'(cfg.grid_width));
    assign h_ext   = $signed(EW'(cfg.grid_height));
    assign col_in  = !col_ext[EW-1] && (col_ext < w_ext);
    assign row_in  = !row_ext[EW-1] && (row_ext < h_ext);
    assign wrap_ok = ((cfg.wrap_mode == WRAP_WIDTH) && (cfg.grid_width != '0))
                  || ((cfg.wrap_mode == WRAP_WM1) && (cfg.grid_width > GRID_W'(1)));
    assign period  = (cfg.wrap_mode == WRAP_WM1) ? cfg.grid_width - GRID_W'(1)
                                                 : cfg.grid_width;
    assign abs_next = in_ch.col_index[COORD_BITS-1] ? COORD_BITS'(-in_ch.col_index)
                                                    : COORD_BITS'(in_ch.col_index);

    always_comb
    begin
        s1_side_next.col_in = col_in;
        s1_side_next.neg    = in_ch.col_index[COORD_BITS-1];
        s1_side_next.col_lo = col_ext[GRID_W-1:0];
        s1_side_next.row    = row_ext[GRID_W-1:0];
        s1_side_next.miss   = !row_in || (!col_in && !wrap_ok)
                           || (cfg.tile_width == '0) || (cfg.tile_height == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_ch.valid;
            s2_vld_reg <= m_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_abs_reg  <= abs_next;
            s1_side_reg <= s1_side_next;
            s2_ix_reg   <= ix_next;
            s2_row_reg  <= m_side.row;
            s2_miss_reg <= m_side.miss;
        end
    end

    tgw_div #(.NW(COORD_BITS), .DW(GRID_W), .SW(SIDE_W)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s1_vld_reg),
        .num      (s1_abs_reg),
        .den      (period),
        .side_in  (s1_side_reg),
        .out_vld  (m_vld),
        .quo      (),
        .rem      (m_rem),
        .side_out (m_side)
    );

    // in-range columns pass through, others take the modulo remainder; negative columns fold back into the period
    always_comb
    begin
        priority if (m_side.col_in)
            ix_next = m_side.col_lo;
        else if (m_side.neg && (m_rem != '0))
            ix_next = period - m_rem;
        else
            ix_next = m_rem;
    end

    tgw_div #(.NW(GRID_W), .DW(TILE_W), .SW(1)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s2_vld_reg),
        .num      (s2_ix_reg),
        .den      (cfg.tile_width),
        .side_in  (s2_miss_reg),
        .out_vld  (x_vld),
        .quo      (qx),
        .rem      (rx),
        .side_out (x_miss)
    );

    tgw_div #(.NW(GRID_W), .DW(TILE_W), .SW(1)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s2_vld_reg),
        .num      (s2_row_reg),
        .den      (cfg.tile_height),
        .side_in  (s2_miss_reg),
        .out_vld  (y_vld),
        .quo      (qy),
        .rem      (ry),
        .side_out (y_miss)
    );

    tgw_offset #(.SAMPLE_BYTES(SAMPLE_BYTES)) u_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .cfg      (cfg),
        .in_vld   (x_vld && y_vld),
        .in_miss  (x_miss[0] || y_miss[0]),
        .qx       (qx),
        .rx       (rx),
        .qy       (qy),
        .ry       (ry),
        .out_vld  (out_ch.valid),
        .out_miss (out_ch.missing),
        .out_off  (out_ch.byte_offset)
    );

    `ASSERT_IMPL(a_miss_zero, out_ch.valid && out_ch.missing, out_ch.byte_offset == '0)
    `ASSERT_IMPL(a_lanes_aligned, 1'b1, x_vld == y_vld)
    `ASSERT_NEXT(a_stall_holds, out_ch.valid && !out_ch.ready, s1_vld_reg == $past(s1_vld_reg))
    `ASSERT_NEXT(a_cfg_mode, cfg_ch.valid && cfg_ch.ready && (cfg_ch.index == REG_WRAP_MODE),
                 cfg.wrap_mode == $past(cfg_ch.data[MODE_W-1:0]))

endmodule
